### src/kmfe_pkg.sv
// ----------------------------------------------------------------------------
// kmfe_pkg
// shared types and constants of the keypad menu field editor
// ----------------------------------------------------------------------------
package kmfe_pkg;

    localparam int unsigned KeyW = 4;

    localparam logic [KeyW-1:0] KEY_NONE  = 4'd0;
    localparam logic [KeyW-1:0] KEY_UP    = 4'd2;
    localparam logic [KeyW-1:0] KEY_LEFT  = 4'd4;
    localparam logic [KeyW-1:0] KEY_RIGHT = 4'd6;
    localparam logic [KeyW-1:0] KEY_DOWN  = 4'd8;

    localparam logic [1:0] CFG_TICKS_PER_COUNT    = 2'd0;
    localparam logic [1:0] CFG_TICKS_PER_SHIFT    = 2'd1;
    localparam logic [1:0] CFG_IDLE_TIMEOUT_TICKS = 2'd2;

    localparam logic [7:0]  RST_TICKS_PER_COUNT    = 8'd5;
    localparam logic [7:0]  RST_TICKS_PER_SHIFT    = 8'd25;
    localparam logic [15:0] RST_IDLE_TIMEOUT_TICKS = 16'd500;
    localparam logic [7:0]  RST_LED_BITS           = 8'h7F;

    localparam logic [1:0] LETTER_LAST = 2'd2;
    localparam logic [3:0] DIGIT_LAST  = 4'd9;
    localparam logic [3:0] DIGIT_RESET = 4'd1;

    typedef enum logic [1:0] {
        FIELD_IDLE   = 2'd0,
        FIELD_LETTER = 2'd1,
        FIELD_DIGIT1 = 2'd2,
        FIELD_DIGIT2 = 2'd3
    } field_t;

    // one tick handed from the input register to the state logic
    typedef struct packed {
        logic            step;
        logic [KeyW-1:0] key;
    } tick_t;

endpackage

### src/keypad_menu_field_editor_core.sv
// ----------------------------------------------------------------------------
// keypad_menu_field_editor_core
// keypad menu editor with bcd stopwatch and rotating led pattern
// ----------------------------------------------------------------------------
// Every accepted word is one timer tick with its scanned key code and yields
// one result word with the menu, stopwatch and led state after that tick.
// A word is taken every clock while in_stall is low; each word passes
// through the input register and then the result register, and the menu
// and timer state is updated between them. in_stall rises only when the
// result register is full and out_stall is high. Configuration
// registers are written through cfg_write, cfg_index and cfg_data; an index
// beyond the three registers is ignored.
module keypad_menu_field_editor_core
    import kmfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  scan_key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  selected_field,
    output logic [1:0]  mode_letter,
    output logic [3:0]  first_digit,
    output logic [3:0]  second_digit,
    output logic [15:0] elapsed_bcd,
    output logic [7:0]  led_pattern,
    output logic [3:0]  shown_key
);

    logic [7:0]  count_cfg_reg;
    logic [7:0]  shift_cfg_reg;
    logic [15:0] timeout_cfg_reg;

    logic        s1_valid_reg;
    logic [3:0]  s1_key_reg;
    logic        out_valid_reg;
    logic        advance;
    tick_t       tick;

    field_t      field_next;
    logic [1:0]  letter_next;
    logic [3:0]  digit1_next;
    logic [3:0]  digit2_next;
    logic [15:0] elapsed_next;
    logic [7:0]  led_next;
    logic        timeout_fire;

    logic [1:0]  field_reg;
    logic [1:0]  letter_reg;
    logic [3:0]  digit1_reg;
    logic [3:0]  digit2_reg;
    logic [15:0] elapsed_reg;
    logic [7:0]  led_reg;
    logic [3:0]  key_out_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_cfg_reg   <= RST_TICKS_PER_COUNT;
            shift_cfg_reg   <= RST_TICKS_PER_SHIFT;
            timeout_cfg_reg <= RST_IDLE_TIMEOUT_TICKS;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                CFG_TICKS_PER_COUNT:    count_cfg_reg   <= cfg_data[7:0];
                CFG_TICKS_PER_SHIFT:    shift_cfg_reg   <= cfg_data[7:0];
                CFG_IDLE_TIMEOUT_TICKS: timeout_cfg_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // input register
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            s1_key_reg <= scan_key;
        end
    end

    assign tick.step = advance;
    assign tick.key  = s1_key_reg;

    kmfe_timers u_timers (
        .clk                (clk),
        .rst_n              (rst_n),
        .tick               (tick),
        .ticks_per_count    (count_cfg_reg),
        .ticks_per_shift    (shift_cfg_reg),
        .idle_timeout_ticks (timeout_cfg_reg),
        .elapsed_next       (elapsed_next),
        .led_next           (led_next),
        .timeout_fire       (timeout_fire)
    );

    kmfe_menu u_menu (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .timeout_fire (timeout_fire),
        .field_next   (field_next),
        .letter_next  (letter_next),
        .digit1_next  (digit1_next),
        .digit2_next  (digit2_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            field_reg   <= field_next;
            letter_reg  <= letter_next;
            digit1_reg  <= digit1_next;
            digit2_reg  <= digit2_next;
            elapsed_reg <= elapsed_next;
            led_reg     <= led_next;
            key_out_reg <= s1_key_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign selected_field = field_reg;
    assign mode_letter    = letter_reg;
    assign first_digit    = digit1_reg;
    assign second_digit   = digit2_reg;
    assign elapsed_bcd    = elapsed_reg;
    assign led_pattern    = led_reg;
    assign shown_key      = key_out_reg;

    // letter stays within a to c
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mode_letter != 2'd3))
        else $error("mode letter out of range");

    // editable digits and stopwatch digits stay decimal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (first_digit <= 4'd9 && second_digit <= 4'd9 &&
                       elapsed_bcd[3:0] <= 4'd9 && elapsed_bcd[7:4] <= 4'd9 &&
                       elapsed_bcd[11:8] <= 4'd9 && elapsed_bcd[15:12] <= 4'd9))
        else $error("non-decimal digit in result");

    // input side only stalls on a held word behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without backpressure");

    // a blocked result word is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

### src/kmfe_timers.sv
// ----------------------------------------------------------------------------
// kmfe_timers
// tick dividers, bcd stopwatch, rotating led pattern and idle timeout counter
// ----------------------------------------------------------------------------
module kmfe_timers
    import kmfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tick_t       tick,
    input  logic [7:0]  ticks_per_count,
    input  logic [7:0]  ticks_per_shift,
    input  logic [15:0] idle_timeout_ticks,
    output logic [15:0] elapsed_next,
    output logic [7:0]  led_next,
    output logic        timeout_fire
);

    logic [7:0]  count_div_reg, count_div_next;
    logic [7:0]  shift_div_reg, shift_div_next;
    logic [15:0] idle_cnt_reg, idle_cnt_next;
    logic [15:0] stopwatch_reg;
    logic [7:0]  led_reg;

    logic [7:0]  count_sum;
    logic [7:0]  shift_sum;
    logic [15:0] idle_sum;
    logic        count_fire;
    logic        shift_fire;
    logic        key_none;

    function automatic logic [15:0] bcd_inc(input logic [15:0] v);
        logic [15:0] res;
        logic        carry;
        logic [3:0]  d;
        res   = '0;
        carry = 1'b1;
        for (int i = 0; i < 4; i++) begin
            d = v[4*i +: 4];
            if (carry) begin
                if (d >= DIGIT_LAST) begin
                    d = 4'd0;
                end
                else begin
                    d     = d + 4'd1;
                    carry = 1'b0;
                end
            end
            res[4*i +: 4] = d;
        end
        return res;
    endfunction

    always_comb
    begin
        key_none = (tick.key == KEY_NONE);

        count_sum      = count_div_reg + 8'd1;
        count_fire     = (count_sum >= ticks_per_count);
        count_div_next = count_fire ? 8'd0 : count_sum;

        shift_sum      = shift_div_reg + 8'd1;
        shift_fire     = (shift_sum >= ticks_per_shift);
        shift_div_next = shift_fire ? 8'd0 : shift_sum;

        idle_sum     = idle_cnt_reg + 16'd1;
        timeout_fire = 1'b0;
        if (key_none) begin
            timeout_fire  = (idle_sum >= idle_timeout_ticks);
            idle_cnt_next = timeout_fire ? 16'd0 : idle_sum;
        end
        else begin
            idle_cnt_next = 16'd0;
        end

        elapsed_next = (count_fire && key_none) ? bcd_inc(stopwatch_reg) : stopwatch_reg;
        led_next     = shift_fire ? {led_reg[0], led_reg[7:1]} : led_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_div_reg <= '0;
            shift_div_reg <= '0;
            idle_cnt_reg  <= '0;
            stopwatch_reg <= '0;
            led_reg       <= RST_LED_BITS;
        end
        else if (tick.step) begin
            count_div_reg <= count_div_next;
            shift_div_reg <= shift_div_next;
            idle_cnt_reg  <= idle_cnt_next;
            stopwatch_reg <= elapsed_next;
            led_reg       <= led_next;
        end
    end

endmodule

### src/kmfe_menu.sv
// ----------------------------------------------------------------------------
// kmfe_menu
// press detection and the three-field menu with letter and digit editing
// ----------------------------------------------------------------------------
module kmfe_menu
    import kmfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tick_t      tick,
    input  logic       timeout_fire,
    output field_t     field_next,
    output logic [1:0] letter_next,
    output logic [3:0] digit1_next,
    output logic [3:0] digit2_next
);

    field_t           field_reg;
    logic [1:0]       letter_reg;
    logic [3:0]       digit1_reg;
    logic [3:0]       digit2_reg;
    logic [KeyW-1:0]  prev_key_reg;
    logic             woke_reg, woke_next;
    logic             pending_reg, pending_next;

    logic any_press, up, down, left, right, pending_now;

    function automatic logic [3:0] digit_step(input logic [3:0] v, input logic inc);
        logic [3:0] r;
        if (inc) begin
            r = (v >= DIGIT_LAST) ? 4'd0 : v + 4'd1;
        end
        else begin
            r = (v == 4'd0) ? DIGIT_LAST : v - 4'd1;
        end
        return r;
    endfunction

    function automatic logic [1:0] letter_step(input logic [1:0] v, input logic inc);
        logic [1:0] r;
        if (inc) begin
            r = (v >= LETTER_LAST) ? 2'd0 : v + 2'd1;
        end
        else begin
            r = (v == 2'd0) ? LETTER_LAST : v - 2'd1;
        end
        return r;
    endfunction

    always_comb
    begin
        any_press   = (tick.key != KEY_NONE) && (prev_key_reg == KEY_NONE);
        up          = (tick.key == KEY_UP) && (prev_key_reg != KEY_UP);
        down        = (tick.key == KEY_DOWN) && (prev_key_reg != KEY_DOWN);
        left        = (tick.key == KEY_LEFT) && (prev_key_reg != KEY_LEFT);
        right       = (tick.key == KEY_RIGHT) && (prev_key_reg != KEY_RIGHT);
        pending_now = pending_reg | timeout_fire;

        field_next   = field_reg;
        letter_next  = letter_reg;
        digit1_next  = digit1_reg;
        digit2_next  = digit2_reg;
        woke_next    = woke_reg;
        pending_next = pending_now;

        if (field_reg == FIELD_IDLE) begin
            woke_next = 1'b1;
            if (any_press) begin
                field_next = FIELD_LETTER;
            end
        end
        else begin
            if (field_reg == FIELD_LETTER && woke_reg) begin
                woke_next = 1'b0;
            end
            else if (right) begin
                unique case (field_reg)
                    FIELD_LETTER: field_next = FIELD_DIGIT1;
                    FIELD_DIGIT1: field_next = FIELD_DIGIT2;
                    default:      field_next = FIELD_LETTER;
                endcase
            end
            else if (left) begin
                unique case (field_reg)
                    FIELD_DIGIT2: field_next = FIELD_DIGIT1;
                    FIELD_DIGIT1: field_next = FIELD_LETTER;
                    default:      field_next = FIELD_DIGIT2;
                endcase
            end
            else if (up || down) begin
                unique case (field_reg)
                    FIELD_LETTER: letter_next = letter_step(letter_reg, up);
                    FIELD_DIGIT1: digit1_next = digit_step(digit1_reg, up);
                    default:      digit2_next = digit_step(digit2_reg, up);
                endcase
            end
            if (pending_now) begin
                pending_next = 1'b0;
                field_next   = FIELD_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            field_reg    <= FIELD_IDLE;
            letter_reg   <= '0;
            digit1_reg   <= DIGIT_RESET;
            digit2_reg   <= DIGIT_RESET;
            prev_key_reg <= KEY_NONE;
            woke_reg     <= 1'b1;
            pending_reg  <= 1'b0;
        end
        else if (tick.step) begin
            field_reg    <= field_next;
            letter_reg   <= letter_next;
            digit1_reg   <= digit1_next;
            digit2_reg   <= digit2_next;
            prev_key_reg <= tick.key;
            woke_reg     <= woke_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

### dv/keypad_menu_field_editor_core_tb.sv
// ----------------------------------------------------------------------------
// keypad_menu_field_editor_core_tb
// self-checking bench for the keypad menu editor, stopwatch and led rotator
// ----------------------------------------------------------------------------
// A queue of key ticks feeds a valid/stall driver. Every accepted tick is run
// through a cycle-free model of the menu, dividers, stopwatch and led pattern,
// and the predicted word is checked field by field against the result port.
// The run walks through directed menu moves, then random key sessions under
// several divider and timeout settings, including zero and full-scale values,
// and ends with a key-free stretch and key traffic sent with no idling.
module keypad_menu_field_editor_core_tb;
    import kmfe_pkg::*;

    localparam logic [3:0] KEY_ENTER    = 4'd5;
    localparam logic [3:0] KEY_MAX_CODE = 4'd15;
    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        field_t      sel;
        logic [1:0]  letter;
        logic [3:0]  first;
        logic [3:0]  second;
        logic [15:0] bcd;
        logic [7:0]  leds;
        logic [3:0]  key;
    } editor_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  scan_key = 4'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  selected_field;
    logic [1:0]  mode_letter;
    logic [3:0]  first_digit;
    logic [3:0]  second_digit;
    logic [15:0] elapsed_bcd;
    logic [7:0]  led_pattern;
    logic [3:0]  shown_key;

    keypad_menu_field_editor_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .scan_key       (scan_key),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .selected_field (selected_field),
        .mode_letter    (mode_letter),
        .first_digit    (first_digit),
        .second_digit   (second_digit),
        .elapsed_bcd    (elapsed_bcd),
        .led_pattern    (led_pattern),
        .shown_key      (shown_key)
    );

    always #2 clk = ~clk;

    logic [3:0]   pending_keys[$];
    editor_word_t expected_words[$];
    int unsigned  queued_count = 0;
    int unsigned  accepted_count = 0;
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;
    logic         in_fired = 1'b0;
    logic         gaps_on = 1'b1;

    // editor state and register copies
    logic [7:0]  count_period;
    logic [7:0]  rotate_period;
    logic [15:0] quiet_limit;
    logic [7:0]  tick_div;
    logic [7:0]  rotate_div;
    logic [15:0] quiet_count;
    logic        timeout_armed;
    logic [3:0]  last_key;
    field_t      cur_field;
    logic [1:0]  letter;
    logic [3:0]  digit_a;
    logic [3:0]  digit_b;
    logic [15:0] watch_bcd;
    logic [7:0]  leds;
    logic        wake_guard;

    task automatic reset_editor();
        count_period  = RST_TICKS_PER_COUNT;
        rotate_period = RST_TICKS_PER_SHIFT;
        quiet_limit   = RST_IDLE_TIMEOUT_TICKS;
        tick_div      = '0;
        rotate_div    = '0;
        quiet_count   = '0;
        timeout_armed = 1'b0;
        last_key      = KEY_NONE;
        cur_field     = FIELD_IDLE;
        letter        = 2'd0;
        digit_a       = DIGIT_RESET;
        digit_b       = DIGIT_RESET;
        watch_bcd     = '0;
        leds          = RST_LED_BITS;
        wake_guard    = 1'b1;
    endtask

    task automatic step_editor(input logic [3:0] key, output editor_word_t w);
        logic       count_hit;
        logic       rotate_hit;
        logic       wake;
        logic       up;
        logic       down;
        logic       left;
        logic       right;
        logic       carry;
        logic [3:0] nib;
        count_hit  = 1'b0;
        rotate_hit = 1'b0;
        tick_div = tick_div + 8'd1;
        if (tick_div >= count_period)
        begin
            count_hit = 1'b1;
            tick_div  = '0;
        end
        rotate_div = rotate_div + 8'd1;
        if (rotate_div >= rotate_period)
        begin
            rotate_hit = 1'b1;
            rotate_div = '0;
        end
        wake  = (key != KEY_NONE) && (last_key == KEY_NONE);
        up    = (key == KEY_UP) && (last_key != KEY_UP);
        down  = (key == KEY_DOWN) && (last_key != KEY_DOWN);
        left  = (key == KEY_LEFT) && (last_key != KEY_LEFT);
        right = (key == KEY_RIGHT) && (last_key != KEY_RIGHT);

        if (key == KEY_NONE)
        begin
            quiet_count = quiet_count + 16'd1;
            if (quiet_count >= quiet_limit)
            begin
                timeout_armed = 1'b1;
                quiet_count   = '0;
            end
        end
        else
            quiet_count = '0;

        // stopwatch holds while a key is down
        if (count_hit && key == KEY_NONE)
        begin
            carry = 1'b1;
            for (int i = 0; i < 4; i++)
            begin
                nib = watch_bcd[4*i +: 4];
                if (carry)
                begin
                    if (nib >= 4'd9)
                        nib = 4'd0;
                    else
                    begin
                        nib   = nib + 4'd1;
                        carry = 1'b0;
                    end
                end
                watch_bcd[4*i +: 4] = nib;
            end
        end
        if (rotate_hit)
            leds = {leds[0], leds[7:1]};

        if (cur_field == FIELD_IDLE)
        begin
            wake_guard = 1'b1;
            if (wake)
                cur_field = FIELD_LETTER;
        end
        else
        begin
            if (cur_field == FIELD_LETTER && wake_guard)
                wake_guard = 1'b0;
            else if (right)
                cur_field = (cur_field == FIELD_DIGIT2) ? FIELD_LETTER
                                                        : field_t'(cur_field + 2'd1);
            else if (left)
                cur_field = (cur_field == FIELD_LETTER) ? FIELD_DIGIT2
                                                        : field_t'(cur_field - 2'd1);
            else if (up || down)
            begin
                case (cur_field)
                    FIELD_LETTER:
                        letter = up ? ((letter >= LETTER_LAST) ? 2'd0 : letter + 2'd1)
                                    : ((letter == 2'd0) ? LETTER_LAST : letter - 2'd1);
                    FIELD_DIGIT1:
                        digit_a = up ? ((digit_a >= DIGIT_LAST) ? 4'd0 : digit_a + 4'd1)
                                     : ((digit_a == 4'd0) ? DIGIT_LAST : digit_a - 4'd1);
                    default:
                        digit_b = up ? ((digit_b >= DIGIT_LAST) ? 4'd0 : digit_b + 4'd1)
                                     : ((digit_b == 4'd0) ? DIGIT_LAST : digit_b - 4'd1);
                endcase
            end
            if (timeout_armed)
            begin
                timeout_armed = 1'b0;
                cur_field     = FIELD_IDLE;
            end
        end
        last_key = key;
        w = '{cur_field, letter, digit_a, digit_b, watch_bcd, leds, key};
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_key(input logic [3:0] k);
        pending_keys.push_back(k);
        queued_count++;
    endtask

    // menu sessions: presses with releases, holds, direct switches, quiet runs, noise
    task automatic add_traffic(input int unsigned count);
        int unsigned stop;
        int unsigned r;
        int unsigned hold;
        logic [3:0]  k;
        stop = queued_count + count;
        while (queued_count < stop)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                case ($urandom_range(9))
                    0, 1: k = KEY_UP;
                    2, 3: k = KEY_DOWN;
                    4, 5: k = KEY_RIGHT;
                    6: k = KEY_LEFT;
                    7: k = KEY_ENTER;
                    default: k = 4'($urandom_range(15, 1));
                endcase
                hold = ($urandom_range(9) == 0) ? $urandom_range(12, 4) : $urandom_range(3, 1);
                repeat (hold) push_key(k);
                if ($urandom_range(99) >= 15)
                    repeat ($urandom_range(4, 1)) push_key(KEY_NONE);
            end
            else if (r < 85)
                repeat ($urandom_range(45, 1)) push_key(KEY_NONE);
            else
                repeat ($urandom_range(4, 1)) push_key(4'($urandom_range(15)));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_periods(input logic [7:0] cnt, input logic [7:0] shift,
                               input logic [15:0] quiet);
        write_reg(CFG_TICKS_PER_COUNT, {8'($urandom_range(255)), cnt});
        write_reg(CFG_TICKS_PER_SHIFT, {8'($urandom_range(255)), shift});
        write_reg(CFG_IDLE_TIMEOUT_TICKS, quiet);
    endtask

    task automatic drain();
        while (accepted_count != queued_count || expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fired)
            begin
                if (pending_keys.size() > 0 && !(gaps_on && $urandom_range(99) < 19))
                begin
                    scan_key <= pending_keys.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= gaps_on && ($urandom_range(99) < 19);
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin : monitor
        editor_word_t w;
        in_fired <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word with none expected, actual %0h", $time,
                             {selected_field, mode_letter, first_digit, second_digit,
                              elapsed_bcd, led_pattern, shown_key});
                    mismatches++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    check_field("selected_field", w.sel, selected_field);
                    check_field("mode_letter", w.letter, mode_letter);
                    check_field("first_digit", w.first, first_digit);
                    check_field("second_digit", w.second, second_digit);
                    check_field("elapsed_bcd", w.bcd, elapsed_bcd);
                    check_field("led_pattern", w.leds, led_pattern);
                    check_field("shown_key", w.key, shown_key);
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_TICKS_PER_COUNT:    count_period  = cfg_data[7:0];
                    CFG_TICKS_PER_SHIFT:    rotate_period = cfg_data[7:0];
                    CFG_IDLE_TIMEOUT_TICKS: quiet_limit   = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                step_editor(scan_key, w);
                expected_words.push_back(w);
                accepted_count++;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        logic [3:0] opening[] = '{
            KEY_NONE, KEY_MAX_CODE, KEY_RIGHT, KEY_NONE, KEY_UP, KEY_NONE,
            KEY_DOWN, KEY_DOWN, KEY_NONE, KEY_DOWN, KEY_NONE, KEY_RIGHT,
            KEY_NONE, KEY_DOWN, KEY_NONE, KEY_DOWN, KEY_NONE, KEY_UP, KEY_NONE,
            KEY_RIGHT, KEY_NONE, KEY_RIGHT, KEY_LEFT, KEY_ENTER, KEY_NONE
        };
        reset_editor();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
            push_key(opening[i]);
        add_traffic(130);
        drain();

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: set_periods(8'd1, 8'd1, 16'd1);
                1: set_periods(8'd255, 8'd255, 16'd65535);
                2: set_periods(8'd0, 8'd0, 16'd0);
                default: set_periods(8'($urandom_range(6, 1)), 8'($urandom_range(30, 1)),
                                     16'($urandom_range(40, 2)));
            endcase
            if (p == 3)
                write_reg(CFG_UNUSED, 16'($urandom_range(65535)));
            add_traffic(150);
            drain();
        end

        // stretch with no idling on either side
        set_periods(8'd1, 8'($urandom_range(8, 1)), 16'd65535);
        gaps_on = 1'b0;
        repeat (100) push_key(KEY_NONE);
        add_traffic(40);
        drain();
        gaps_on = 1'b1;

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### keypad_menu_field_editor_core.f
src/kmfe_pkg.sv
src/kmfe_timers.sv
src/kmfe_menu.sv
src/keypad_menu_field_editor_core.sv
dv/keypad_menu_field_editor_core_tb.sv
